// ----- rtl/core/pidpc_pkg.sv -----
// shared widths, register indexes and status type of the pid position controller
package pidpc_pkg;

  localparam int GainWidth     = 32;
  localparam int MeasWidth     = 32;
  localparam int TimeWidth     = 32;
  localparam int TolWidth      = 31;
  localparam int ErrWidth      = 33;
  localparam int ErrLoWidth    = 16;
  localparam int DiffWidth     = 34;
  localparam int DiffLoWidth   = 17;
  localparam int DriveWidth    = 8;
  localparam int PowerWidth    = 16;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 32;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_TURN_MODE     = 3'd0,
    CFG_TARGET_VALUE  = 3'd1,
    CFG_TOLERANCE     = 3'd2,
    CFG_GAIN_P        = 3'd3,
    CFG_GAIN_I        = 3'd4,
    CFG_GAIN_D        = 3'd5,
    CFG_TIME_LIMIT_MS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic pwr_en;
    logic active;
    logic done;
    logic tout;
  } move_status_t;

endpackage

// ----- rtl/core/pidpc_tick_if.sv -----
// tick channel: start flag, measurement and time stamp
interface pidpc_tick_if import pidpc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        start_move;
  logic signed [MeasWidth-1:0] measurement;
  logic [TimeWidth-1:0]        now_ms;

  modport source (output valid, output start_move, output measurement, output now_ms,
                  input ready);
  modport sink   (input valid, input start_move, input measurement, input now_ms,
                  output ready);
endinterface

// ----- rtl/core/pidpc_drive_if.sv -----
// drive channel: motor commands and move status
interface pidpc_drive_if import pidpc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DriveWidth-1:0] left_drive;
  logic signed [DriveWidth-1:0] right_drive;
  logic                         move_active;
  logic                         move_done;
  logic                         timed_out;

  modport source (output valid, output left_drive, output right_drive, output move_active,
                  output move_done, output timed_out, input ready);
  modport sink   (input valid, input left_drive, input right_drive, input move_active,
                  input move_done, input timed_out, output ready);
endinterface

// ----- rtl/core/pidpc_mac.sv -----
// pipelined multiply, accumulate and saturate of the pid power term
module pidpc_mac import pidpc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int DRIVE_LIMIT    = 127,
  parameter int SUM_WIDTH      = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ErrWidth-1:0]   err,
  input  logic signed [DiffWidth-1:0]  deriv,
  input  logic signed [SUM_WIDTH-1:0]  sum,
  input  move_status_t                 in_status,
  input  logic signed [GainWidth-1:0]  gain_p,
  input  logic signed [GainWidth-1:0]  gain_i,
  input  logic signed [GainWidth-1:0]  gain_d,
  input  logic                         turn_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DriveWidth-1:0] left_drive,
  output logic signed [DriveWidth-1:0] right_drive,
  output move_status_t                 out_status
);

  localparam int SumLoWidth = SUM_WIDTH / 2;
  localparam int SumHiWidth = SUM_WIDTH - SumLoWidth;
  localparam int AccWidth   = SUM_WIDTH + 34;
  localparam int PeLoWidth  = ErrLoWidth + 1 + GainWidth;
  localparam int PeHiWidth  = ErrWidth - ErrLoWidth + GainWidth;
  localparam int PdLoWidth  = DiffLoWidth + 1 + GainWidth;
  localparam int PdHiWidth  = DiffWidth - DiffLoWidth + GainWidth;
  localparam int PsLoWidth  = SumLoWidth + 1 + GainWidth;
  localparam int PsHiWidth  = SumHiWidth + GainWidth;

  // partial product stage
  logic                        pa_valid;
  move_status_t                pa_status;
  logic signed [PeLoWidth-1:0] pe_lo;
  logic signed [PeHiWidth-1:0] pe_hi;
  logic signed [PdLoWidth-1:0] pd_lo;
  logic signed [PdHiWidth-1:0] pd_hi;
  logic signed [PsLoWidth-1:0] ps_lo;
  logic signed [PsHiWidth-1:0] ps_hi;

  // product stage
  logic                       pb_valid;
  move_status_t               pb_status;
  logic signed [AccWidth-1:0] prod_p;
  logic signed [AccWidth-1:0] prod_i;
  logic signed [AccWidth-1:0] prod_d;

  logic pa_ready;
  logic pb_ready;
  logic pc_ready;

  logic signed [AccWidth-1:0]   acc;
  logic signed [AccWidth-1:0]   quot;
  logic signed [AccWidth-1:0]   quot_trunc;
  logic signed [AccWidth-1:0]   limit;
  logic signed [PowerWidth-1:0] power;
  logic signed [PowerWidth-1:0] power_right;
  logic                         round_up;

  assign pc_ready = !out_valid || out_ready;
  assign pb_ready = !pb_valid || pc_ready;
  assign pa_ready = !pa_valid || pb_ready;
  assign in_ready = pa_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
    end else if (pa_ready) begin
      pa_valid <= in_valid;
    end
    if (pa_ready && in_valid) begin
      pa_status <= in_status;
      pe_lo     <= $signed({1'b0, err[ErrLoWidth-1:0]}) * gain_p;
      pe_hi     <= $signed(err[ErrWidth-1:ErrLoWidth]) * gain_p;
      pd_lo     <= $signed({1'b0, deriv[DiffLoWidth-1:0]}) * gain_d;
      pd_hi     <= $signed(deriv[DiffWidth-1:DiffLoWidth]) * gain_d;
      ps_lo     <= $signed({1'b0, sum[SumLoWidth-1:0]}) * gain_i;
      ps_hi     <= $signed(sum[SUM_WIDTH-1:SumLoWidth]) * gain_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_valid <= 1'b0;
    end else if (pb_ready) begin
      pb_valid <= pa_valid;
    end
    if (pb_ready && pa_valid) begin
      pb_status <= pa_status;
      prod_p    <= (AccWidth'(pe_hi) <<< ErrLoWidth) + AccWidth'(pe_lo);
      prod_d    <= (AccWidth'(pd_hi) <<< DiffLoWidth) + AccWidth'(pd_lo);
      prod_i    <= (AccWidth'(ps_hi) <<< SumLoWidth) + AccWidth'(ps_lo);
    end
  end

  // scale down (toward zero), clip to the drive limit; zero if power off
  always_comb begin
    acc        = prod_p + prod_i + prod_d;
    quot       = acc >>> GAIN_FRAC_BITS;
    round_up   = acc[AccWidth-1] && (|acc[GAIN_FRAC_BITS-1:0]);
    quot_trunc = quot + AccWidth'(round_up);
    limit      = AccWidth'(DRIVE_LIMIT);
    if (!pb_status.pwr_en) begin
      power = '0;
    end else if (quot_trunc > limit) begin
      power = PowerWidth'(DRIVE_LIMIT);
    end else if (quot_trunc < -limit) begin
      power = -PowerWidth'(DRIVE_LIMIT);
    end else begin
      power = quot_trunc[PowerWidth-1:0];
    end
    power_right = turn_mode ? -power : power;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pc_ready) begin
      out_valid <= pb_valid;
    end
    if (pc_ready && pb_valid) begin
      out_status  <= pb_status;
      left_drive  <= power[DriveWidth-1:0];
      right_drive <= power_right[DriveWidth-1:0];
    end
  end

endmodule

// ----- rtl/core/pid_position_controller.sv -----
// top level of the pid position controller: registers, move state and result channel
//
// channel   | dir | transfer when          | payload
// ----------+-----+------------------------+------------------------------------------------
// cfg       | in  | cfg_we high            | cfg_index, cfg_data (widest register, 32 bits)
// tick      | in  | tick.valid & tick.ready| start_move, measurement, now_ms
// drive     | out | drive.valid&drive.ready| left_drive, right_drive, move_active, move_done,
//           |     |                        | timed_out
//
// one tick per cycle sustained while drive.ready stays high; a result reaches the output register
// after its tick transfer, passing the input register, move state stage and three mac stages
// move state (active flag, reference, integral, previous error, start stamp) is updated as a tick
// leaves the input register, so the next tick in the input register already sees it
// synchronous reset clears the configuration registers, the move state and every stage valid
// each stage holds while the one after it is full and stalled, so bubbles are squeezed out
module pid_position_controller import pidpc_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int DRIVE_LIMIT    = 127,
  parameter int SUM_WIDTH      = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  pidpc_tick_if.sink               tick,
  pidpc_drive_if.source            drive
);

  // configuration registers
  logic                        turn_mode;
  logic [MeasWidth-1:0]        target_value;
  logic [TolWidth-1:0]         tolerance;
  logic signed [GainWidth-1:0] gain_p;
  logic signed [GainWidth-1:0] gain_i;
  logic signed [GainWidth-1:0] gain_d;
  logic [TimeWidth-1:0]        time_limit_ms;

  // move state
  logic                        active_flag;
  logic [MeasWidth-1:0]        reference_value;
  logic [TimeWidth-1:0]        start_time;
  logic signed [ErrWidth-1:0]  previous_error;
  logic signed [SUM_WIDTH-1:0] error_sum;

  // input register
  logic                 s1_valid;
  logic                 s1_start;
  logic [MeasWidth-1:0] s1_meas;
  logic [TimeWidth-1:0] s1_now;

  // move state stage
  logic                        s2_valid;
  logic signed [ErrWidth-1:0]  s2_err;
  logic signed [DiffWidth-1:0] s2_deriv;
  logic signed [SUM_WIDTH-1:0] s2_sum;
  move_status_t                s2_status;

  logic s1_ready;
  logic s2_ready;
  logic s1_fire;
  logic mac_ready;

  // combinational move logic
  logic [MeasWidth-1:0]        ref_now;
  logic [MeasWidth-1:0]        diff;
  logic signed [ErrWidth-1:0]  err;
  logic signed [ErrWidth-1:0]  prev_use;
  logic signed [SUM_WIDTH-1:0] sum_use;
  logic [ErrWidth-1:0]         chk;
  logic [ErrWidth-1:0]         chk_mag;
  logic                        in_tol;
  logic [TimeWidth-1:0]        stamp;
  logic [TimeWidth-1:0]        elapsed;
  logic                        late;
  logic                        armed;
  logic                        computed;
  logic signed [DiffWidth-1:0] deriv;
  logic [SUM_WIDTH:0]          sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  move_status_t                status;

  move_status_t mac_status;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_mode     <= 1'b0;
      target_value  <= '0;
      tolerance     <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      time_limit_ms <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TURN_MODE:     turn_mode     <= cfg_data[0];
        CFG_TARGET_VALUE:  target_value  <= cfg_data[MeasWidth-1:0];
        CFG_TOLERANCE:     tolerance     <= cfg_data[TolWidth-1:0];
        CFG_GAIN_P:        gain_p        <= cfg_data[GainWidth-1:0];
        CFG_GAIN_I:        gain_i        <= cfg_data[GainWidth-1:0];
        CFG_GAIN_D:        gain_d        <= cfg_data[GainWidth-1:0];
        CFG_TIME_LIMIT_MS: time_limit_ms <= cfg_data[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain, back from the mac pipeline
  assign s2_ready   = !s2_valid || mac_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign s1_fire    = s1_valid && s2_ready;
  assign tick.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= tick.valid;
    end
    if (s1_ready && tick.valid) begin
      s1_start <= tick.start_move;
      s1_meas  <= tick.measurement;
      s1_now   <= tick.now_ms;
    end
  end

  always_comb begin
    // a start re-arms at once: fresh reference, stamp, and cleared history
    ref_now  = s1_start ? (turn_mode ? '0 : s1_meas) : reference_value;
    diff     = s1_meas - ref_now;
    err      = {target_value[MeasWidth-1], target_value} - {diff[MeasWidth-1], diff};
    prev_use = s1_start ? '0 : previous_error;
    sum_use  = s1_start ? '0 : error_sum;

    // start tick tests the fresh error, later ticks the one left by the last tick
    chk     = s1_start ? err : previous_error;
    chk_mag = chk[ErrWidth-1] ? (~chk + 1'b1) : chk;
    in_tol  = chk_mag <= {2'b00, tolerance};

    stamp   = s1_start ? s1_now : start_time;
    elapsed = s1_now - stamp;
    late    = elapsed > time_limit_ms;

    armed    = s1_start || active_flag;
    computed = armed && !in_tol;

    deriv = {err[ErrWidth-1], err} - {prev_use[ErrWidth-1], prev_use};

    // integral with saturation at the signed limits
    sum_wide = {sum_use[SUM_WIDTH-1], sum_use}
             + {{(SUM_WIDTH + 1 - ErrWidth){err[ErrWidth-1]}}, err};
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end

    status.done   = armed && (in_tol || late);
    status.tout   = computed && late;
    status.pwr_en = computed && !late;
    status.active = armed && !(in_tol || late);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag     <= 1'b0;
      reference_value <= '0;
      start_time      <= '0;
      previous_error  <= '0;
      error_sum       <= '0;
    end else if (s1_fire) begin
      active_flag <= status.active;
      if (s1_start) begin
        reference_value <= ref_now;
        start_time      <= s1_now;
      end
      // a start that finishes at once still leaves the history cleared
      if (computed) begin
        previous_error <= err;
        error_sum      <= sum_next;
      end else if (s1_start) begin
        previous_error <= '0;
        error_sum      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s1_fire) begin
      s2_err    <= err;
      s2_deriv  <= deriv;
      s2_sum    <= sum_use;
      s2_status <= status;
    end
  end

  // gain multiplies, sum, scale and clip
  pidpc_mac #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DRIVE_LIMIT    (DRIVE_LIMIT),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_ready    (mac_ready),
    .err         (s2_err),
    .deriv       (s2_deriv),
    .sum         (s2_sum),
    .in_status   (s2_status),
    .gain_p      (gain_p),
    .gain_i      (gain_i),
    .gain_d      (gain_d),
    .turn_mode   (turn_mode),
    .out_valid   (drive.valid),
    .out_ready   (drive.ready),
    .left_drive  (drive.left_drive),
    .right_drive (drive.right_drive),
    .out_status  (mac_status)
  );

  assign drive.move_active = mac_status.active;
  assign drive.move_done   = mac_status.done;
  assign drive.timed_out   = mac_status.tout;

endmodule

// ----- rtl/core/pidpc_checker.sv -----
// port checker for the pid position controller, bound to the top level
module pidpc_checker import pidpc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  drive_valid,
  input logic                  drive_ready,
  input logic [DriveWidth-1:0] left_drive,
  input logic [DriveWidth-1:0] right_drive,
  input logic                  move_active,
  input logic                  move_done,
  input logic                  timed_out
);

  // a finished move leaves the motors stopped and the move inactive
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    drive_valid && move_done |-> !move_active && left_drive == '0 && right_drive == '0)
    else $error("finish with drive or active move");

  // a timeout is always a finish
  a_tout_done: assert property (@(posedge clk) disable iff (rst)
    drive_valid && timed_out |-> move_done)
    else $error("timeout without finish");

  // sides are equal or opposite
  a_sides: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> right_drive == left_drive || right_drive == (~left_drive + 8'd1))
    else $error("sides neither equal nor opposite");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    drive_valid && !drive_ready |=> drive_valid && $stable(left_drive)
      && $stable(right_drive) && $stable(move_active) && $stable(move_done)
      && $stable(timed_out))
    else $error("stalled result changed");

  // nothing leaves straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !drive_valid)
    else $error("result valid after reset");

endmodule

bind pid_position_controller pidpc_checker u_pidpc_checker (
  .clk         (clk),
  .rst         (rst),
  .drive_valid (drive.valid),
  .drive_ready (drive.ready),
  .left_drive  (drive.left_drive),
  .right_drive (drive.right_drive),
  .move_active (drive.move_active),
  .move_done   (drive.move_done),
  .timed_out   (drive.timed_out)
);
